FILE: hw/rtl/axt_pkg.sv
// Shared types and constants of the address cross-reference tracker.
// Holds the decoded micro-op that passes from the front end to the back end.
// No dependencies.
package axt_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_W    = 5;
  localparam int ADDR_W   = 64;
  localparam int INSTR_W  = 32;

  // Default queue depths; both must be at least 2.
  localparam int UOP_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic CFG_TARGET_REG   = 1'b0;
  localparam logic CFG_TARGET_VALUE = 1'b1;

  // Opcode masks and match values.
  localparam logic [31:0] MASK_ADR      = 32'h9F00_0000;
  localparam logic [31:0] MATCH_ADR     = 32'h1000_0000;
  localparam logic [31:0] MATCH_ADRP    = 32'h9000_0000;
  localparam logic [31:0] MASK_IMM      = 32'hFFC0_0000;
  localparam logic [31:0] MATCH_ADD_IMM = 32'h9100_0000;
  localparam logic [31:0] MATCH_LDR_UOF = 32'hF940_0000;
  localparam logic [31:0] MASK_LDR_LIT  = 32'hFF00_0000;
  localparam logic [31:0] MATCH_LDR_LIT = 32'h5800_0000;
  localparam logic [31:0] INSTR_RET     = 32'hD65F_03C0;
  localparam logic [63:0] PAGE_MASK     = ~64'hFFF;

  typedef enum logic [1:0] {
    OP_NONE,   // no register change
    OP_SET,    // rd <= value
    OP_ADD,    // rd <= reg[rn] + value
    OP_CLEAR   // all registers cleared
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              adrp;
    logic              new_search;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  rn;
    logic [ADDR_W-1:0] value;
    logic [ADDR_W-1:0] pc;
  } uop_t;

endpackage

FILE: hw/rtl/axt_queue.sv
// Small first-in first-out queue of flop slots with an occupancy count.
// Used between front and back end and for the result side.
// Depends on nothing.
module axt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/axt_front.sv
// Front end: decodes one instruction word into a micro-op and forms
// pc-relative addresses. Depends on axt_pkg.
module axt_front (
  input  logic                        push,
  input  logic [31:0]                 instr,
  input  logic [63:0]                 instr_addr,
  input  logic                        new_search,
  input  logic                        uq_full,
  output logic                        full,
  output logic                        uq_push,
  output axt_pkg::uop_t               uq_data
);

  logic [18:0] imm19;
  logic [20:0] imm_hilo;
  logic [63:0] base;
  logic [63:0] offset;
  logic        is_adrp;

  assign full     = uq_full;
  assign uq_push  = push && !uq_full;
  assign imm19    = instr[23:5];
  assign imm_hilo = {instr[23:5], instr[30:29]};
  assign is_adrp  = ((instr & axt_pkg::MASK_ADR) == axt_pkg::MATCH_ADRP)
                    && ((instr & axt_pkg::MASK_LDR_LIT) != axt_pkg::MATCH_LDR_LIT);

  always_comb begin
    uq_data            = '0;
    uq_data.rd         = instr[4:0];
    uq_data.rn         = instr[9:5];
    uq_data.pc         = instr_addr;
    uq_data.new_search = new_search;
    uq_data.op         = axt_pkg::OP_NONE;
    base               = instr_addr;
    offset             = '0;
    // first match wins
    if ((instr & axt_pkg::MASK_LDR_LIT) == axt_pkg::MATCH_LDR_LIT) begin
      uq_data.op = axt_pkg::OP_SET;
      offset     = {{43{imm19[18]}}, imm19, 2'b00};
    end else if ((instr & axt_pkg::MASK_ADR) == axt_pkg::MATCH_ADR) begin
      uq_data.op = axt_pkg::OP_SET;
      offset     = {{43{imm_hilo[20]}}, imm_hilo};
    end else if (is_adrp) begin
      uq_data.op   = axt_pkg::OP_SET;
      uq_data.adrp = 1'b1;
      base         = instr_addr & axt_pkg::PAGE_MASK;
      offset       = {{31{imm_hilo[20]}}, imm_hilo, 12'h000};
    end else if ((instr & axt_pkg::MASK_IMM) == axt_pkg::MATCH_ADD_IMM) begin
      uq_data.op = axt_pkg::OP_ADD;
      offset     = {52'h0, instr[21:10]};
    end else if ((instr & axt_pkg::MASK_IMM) == axt_pkg::MATCH_LDR_UOF) begin
      uq_data.op = axt_pkg::OP_ADD;
      offset     = {49'h0, instr[21:10], 3'b000};
    end else if (instr == axt_pkg::INSTR_RET) begin
      uq_data.op = axt_pkg::OP_CLEAR;
    end
    // set ops carry the finished address, add ops carry the immediate
    uq_data.value = (uq_data.op == axt_pkg::OP_SET) ? (base + offset) : offset;
  end

endmodule

FILE: hw/rtl/axt_back.sv
// Back end: tracked register file, target shadow, hit check and config.
// Depends on axt_pkg; fed by the micro-op queue, feeds the result queue.
module axt_back #(
  parameter int OUT_DEPTH = axt_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [63:0]                    cfg_wdata,
  input  logic                           uq_empty,
  input  axt_pkg::uop_t                  uq_data,
  output logic                           uq_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output logic [63:0]                    res_data
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int RW = axt_pkg::REG_W;

  // configuration
  logic [RW-1:0] tgt_reg;
  logic [63:0]   tgt_value;
  logic          reload_req;
  logic          reload_rd;

  // register file and valid bits
  logic [63:0]                  regs [axt_pkg::NUM_REGS];
  logic [axt_pkg::NUM_REGS-1:0] reg_valid;
  logic [axt_pkg::NUM_REGS-1:0] reg_valid_next;
  logic [63:0]                  rdata;
  logic                         rdata_valid;
  logic [RW-1:0]                rd_addr;

  // execute stage
  logic          x_valid;
  axt_pkg::uop_t x_op;
  logic          byp_hit;
  logic          byp_zero;
  logic [63:0]   byp_val;

  // tracker state
  logic          done;
  logic [63:0]   tgt_val;

  logic [63:0]   src;
  logic [63:0]   wr_val;
  logic          wen;
  logic          clr_all;
  logic [63:0]   tgt_cur;
  logic [63:0]   tgt_new;
  logic          done_cur;
  logic          hit;
  logic [CW:0]   in_flight;

  assign in_flight = {1'b0, out_count} + {{CW{1'b0}}, x_valid};
  assign uq_pop    = !uq_empty && !reload_req && !reload_rd
                     && (in_flight < (CW+1)'(OUT_DEPTH));
  assign rd_addr   = reload_req ? tgt_reg : uq_data.rn;

  always_comb begin
    if (x_op.new_search) begin
      src = '0;
    end else if (byp_hit) begin
      src = byp_val;
    end else if (byp_zero || !rdata_valid) begin
      src = '0;
    end else begin
      src = rdata;
    end
    wen     = 1'b0;
    wr_val  = x_op.value;
    clr_all = x_op.new_search;
    case (x_op.op)
      axt_pkg::OP_SET:   wen = 1'b1;
      axt_pkg::OP_ADD: begin
        wen    = 1'b1;
        wr_val = src + x_op.value;
      end
      axt_pkg::OP_CLEAR: clr_all = 1'b1;
      default:           wen = 1'b0;
    endcase
    tgt_cur  = x_op.new_search ? '0 : tgt_val;
    done_cur = x_op.new_search ? 1'b0 : done;
    if (x_op.op == axt_pkg::OP_CLEAR) begin
      tgt_new = '0;
    end else if (wen && (x_op.rd == tgt_reg)) begin
      tgt_new = wr_val;
    end else begin
      tgt_new = tgt_cur;
    end
    hit      = x_valid && !x_op.adrp && !done_cur && (x_op.rd == tgt_reg)
               && ((tgt_value == '0) || (tgt_new == tgt_value));
    res_push = hit;
    res_data = (tgt_value == '0) ? tgt_new : x_op.pc;
  end

  always_comb begin
    reg_valid_next = reg_valid;
    if (x_valid && clr_all) begin
      reg_valid_next = '0;
    end
    if (x_valid && wen) begin
      reg_valid_next[x_op.rd] = 1'b1;
    end
  end

  // register file: one write, one registered read
  always_ff @(posedge clk) begin
    if (x_valid && wen) begin
      regs[x_op.rd] <= wr_val;
    end
    rdata       <= regs[rd_addr];
    rdata_valid <= reg_valid[rd_addr];
  end

  // operand bypass from the op that retires on the read edge
  always_ff @(posedge clk) begin
    x_op     <= uq_data;
    byp_val  <= wr_val;
    byp_hit  <= x_valid && wen && (x_op.rd == uq_data.rn);
    byp_zero <= x_valid && clr_all;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid    <= 1'b0;
      reg_valid  <= '0;
      done       <= 1'b0;
      tgt_val    <= '0;
      tgt_reg    <= '0;
      tgt_value  <= '0;
      reload_req <= 1'b0;
      reload_rd  <= 1'b0;
    end else begin
      x_valid   <= uq_pop;
      reg_valid <= reg_valid_next;
      if (x_valid) begin
        tgt_val <= tgt_new;
        done    <= hit || done_cur;
      end else if (reload_rd) begin
        tgt_val <= rdata_valid ? rdata : '0;
      end
      // refresh the target shadow after the target register changes
      reload_rd <= reload_req && !x_valid;
      if (cfg_we && (cfg_addr == axt_pkg::CFG_TARGET_REG)) begin
        tgt_reg    <= cfg_wdata[RW-1:0];
        reload_req <= 1'b1;
      end else if (!x_valid) begin
        reload_req <= 1'b0;
      end
      if (cfg_we && (cfg_addr == axt_pkg::CFG_TARGET_VALUE)) begin
        tgt_value <= cfg_wdata;
      end
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    uq_pop |-> !uq_empty)
    else $error("micro-op popped from empty queue");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < CW'(OUT_DEPTH)))
    else $error("result pushed without queue room");

  a_done_after_hit: assert property (@(posedge clk) disable iff (rst)
    res_push |=> done)
    else $error("search not closed after hit");

  a_reload_idle: assert property (@(posedge clk) disable iff (rst)
    reload_rd |-> !x_valid)
    else $error("shadow reload overlaps an executing op");

endmodule

FILE: hw/rtl/arm64_address_xref_tracker_unit.sv
// ARM64 address cross-reference tracker, top level.
// Uses axt_pkg, axt_front, axt_queue and axt_back.
//
// Scans ARM64 instruction words (with their addresses) and tracks the
// addresses built by LDR literal, ADR, ADRP, ADD immediate and LDR unsigned
// offset in 32 shadow registers; RET and new_search clear them. After every
// non-ADRP instruction whose Rd is target_reg it checks for a hit: with
// target_value zero it reports the register value, otherwise the address of
// the instruction that made the register equal target_value. One answer per
// search. Rate: one instruction per clock while the micro-op queue has room
// and the back end is not stalled; an item passes the micro-op queue, then
// the execute stage with its registered register-file read, to the result
// queue. A write to target_reg holds the back end while the target shadow
// is reloaded from the register file; pushes still land in the micro-op queue.
module arm64_address_xref_tracker_unit #(
  parameter int UOP_DEPTH = axt_pkg::UOP_DEPTH_DEF,
  parameter int OUT_DEPTH = axt_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // instruction side
  input  logic        push,
  output logic        full,
  input  logic [31:0] instr,
  input  logic [63:0] instr_addr,
  input  logic        new_search,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [63:0] answer,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int UOP_W = $bits(axt_pkg::uop_t);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic                 uq_full;
  logic                 uq_push;
  axt_pkg::uop_t        uq_in;
  logic [UOP_W-1:0]     uq_out;
  logic                 uq_empty;
  logic                 uq_pop;
  logic                 res_push;
  logic [63:0]          res_data;
  logic [OCW-1:0]       out_count;

  // decode and classify each transaction on the way in
  axt_front u_front (
    .push       (push),
    .instr      (instr),
    .instr_addr (instr_addr),
    .new_search (new_search),
    .uq_full    (uq_full),
    .full       (full),
    .uq_push    (uq_push),
    .uq_data    (uq_in)
  );

  // decouple the front from the register file
  axt_queue #(
    .WIDTH (UOP_W),
    .DEPTH (UOP_DEPTH)
  ) u_uop_q (
    .clk       (clk),
    .rst       (rst),
    .push      (uq_push),
    .push_data (uq_in),
    .full      (uq_full),
    .pop       (uq_pop),
    .pop_data  (uq_out),
    .empty     (uq_empty),
    .count     ()
  );

  // execute: register file update and hit check
  axt_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .uq_empty  (uq_empty),
    .uq_data   (axt_pkg::uop_t'(uq_out)),
    .uq_pop    (uq_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // hold answers until the consumer takes them; the back end only
  // issues an op when a slot is guaranteed
  axt_queue #(
    .WIDTH (64),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (),
    .pop       (pop),
    .pop_data  (answer),
    .empty     (empty),
    .count     (out_count)
  );

endmodule
